### design/sdtl_pkg.sv
// sdtl_pkg: shared types and constants of the sorted deadline timer list
// no dependencies; used by sdtl_seq, the top level and the checker
package sdtl_pkg;

  localparam int unsigned SLOTS_DEF   = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam logic [31:0] EXPIRY_WINDOW = 32'h1000_0000;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] KIND_STARTED   = 2'd0;
  localparam logic [1:0] KIND_CANCELLED = 2'd1;
  localparam logic [1:0] KIND_EXPIRED   = 2'd2;
  localparam logic [1:0] KIND_TICK_IDLE = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  slot;
    logic [31:0] delay_ticks;
    logic [31:0] user_arg;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot_out;
    logic [31:0] arg_out;
    logic        status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } emit_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UL_HEAD,
    ST_UL_NXT,
    ST_UL_WALK,
    ST_INS_RD,
    ST_INS_WALK,
    ST_INS_LINK,
    ST_INS_PREV,
    ST_TK_RD,
    ST_TK_CHK,
    ST_DONE
  } state_e;

endpackage

### design/sdtl_ram.sv
// sdtl_ram: generic synchronous ram, one write port, one registered read port
// no dependencies
module sdtl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/sdtl_seq.sv
// sdtl_seq: list sequencer, link and timer memories, armed flags, time base
// depends on sdtl_pkg and sdtl_ram
module sdtl_seq #(
  parameter int unsigned SLOTS = sdtl_pkg::SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sdtl_pkg::req_t      in_req_i,
  input  logic                emit_ready_i,
  output sdtl_pkg::emit_t     emit_o
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LW = $clog2(SLOTS + 1);
  localparam int unsigned KW = $clog2(sdtl_pkg::MAX_RESULTS + 1);
  localparam logic [LW-1:0] NIL = LW'(SLOTS);
  localparam logic [KW-1:0] CNT_MAX = KW'(sdtl_pkg::MAX_RESULTS);

  sdtl_pkg::state_e state_q, state_d;
  sdtl_pkg::req_t   req_q, req_d;
  logic [31:0]      time_q, time_d;
  logic [31:0]      dl_q, dl_d;
  logic [LW-1:0]    head_q, head_d;
  logic [LW-1:0]    cur_q, cur_d;
  logic [LW-1:0]    prev_q, prev_d;
  logic [LW-1:0]    nxt_q, nxt_d;
  logic [SLOTS-1:0] armed_q, armed_d;
  logic             was_q, was_d;
  logic [KW-1:0]    cnt_q, cnt_d;
  logic             pend_v_q, pend_v_d;
  logic [3:0]       pend_slot_q, pend_slot_d;
  logic [31:0]      pend_arg_q, pend_arg_d;

  logic          l_we, l_re, d_we, d_re;
  logic [SW-1:0] l_waddr, l_raddr, d_waddr, d_raddr;
  logic [LW-1:0] l_wdata, l_rdata;
  logic [63:0]   d_wdata, d_rdata;

  logic          s_in_ok, armed_in, expired, ins_stop, tk_end;
  logic [SW-1:0] s_in_idx, s_idx;
  logic [LW-1:0] s_link;
  sdtl_pkg::res_t final_res;

  sdtl_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (l_we),
    .waddr_i(l_waddr),
    .wdata_i(l_wdata),
    .re_i   (l_re),
    .raddr_i(l_raddr),
    .rdata_o(l_rdata)
  );

  sdtl_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (d_we),
    .waddr_i(d_waddr),
    .wdata_i(d_wdata),
    .re_i   (d_re),
    .raddr_i(d_raddr),
    .rdata_o(d_rdata)
  );

  assign in_ready_o = (state_q == sdtl_pkg::ST_IDLE);
  assign s_in_ok    = 32'(in_req_i.slot) < SLOTS;
  assign s_in_idx   = SW'(in_req_i.slot);
  assign armed_in   = s_in_ok && armed_q[s_in_idx];
  assign s_idx      = SW'(req_q.slot);
  assign s_link     = LW'(req_q.slot);
  assign expired    = (time_q - d_rdata[63:32]) < sdtl_pkg::EXPIRY_WINDOW;
  assign ins_stop   = (cur_q == NIL) || (dl_q < d_rdata[63:32]);
  assign tk_end     = (cnt_q == CNT_MAX) || (head_q == NIL);

  always_comb begin
    if (pend_v_q) begin
      final_res = '{kind: sdtl_pkg::KIND_EXPIRED, slot_out: pend_slot_q,
                    arg_out: pend_arg_q, status: 1'b0, last: 1'b1};
    end else begin
      final_res = '{kind: sdtl_pkg::KIND_TICK_IDLE, slot_out: 4'd0,
                    arg_out: 32'd0, status: 1'b0, last: 1'b1};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sdtl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (in_req_i.cmd)
            sdtl_pkg::CMD_START: begin
              if (!s_in_ok) state_d = sdtl_pkg::ST_DONE;
              else if (armed_in) state_d = sdtl_pkg::ST_UL_HEAD;
              else state_d = sdtl_pkg::ST_INS_RD;
            end
            sdtl_pkg::CMD_CANCEL: begin
              state_d = armed_in ? sdtl_pkg::ST_UL_HEAD : sdtl_pkg::ST_DONE;
            end
            sdtl_pkg::CMD_TICK: state_d = sdtl_pkg::ST_TK_RD;
            default:            state_d = sdtl_pkg::ST_IDLE;
          endcase
        end
      end
      sdtl_pkg::ST_UL_HEAD: state_d = sdtl_pkg::ST_UL_NXT;
      sdtl_pkg::ST_UL_NXT: begin
        if (head_q == s_link) begin
          state_d = (req_q.cmd == sdtl_pkg::CMD_START) ? sdtl_pkg::ST_INS_RD
                                                       : sdtl_pkg::ST_DONE;
        end else begin
          state_d = sdtl_pkg::ST_UL_WALK;
        end
      end
      sdtl_pkg::ST_UL_WALK: begin
        if (l_rdata == s_link) begin
          state_d = (req_q.cmd == sdtl_pkg::CMD_START) ? sdtl_pkg::ST_INS_RD
                                                       : sdtl_pkg::ST_DONE;
        end
      end
      sdtl_pkg::ST_INS_RD: state_d = sdtl_pkg::ST_INS_WALK;
      sdtl_pkg::ST_INS_WALK: begin
        if (ins_stop) state_d = sdtl_pkg::ST_INS_LINK;
      end
      sdtl_pkg::ST_INS_LINK: begin
        state_d = (prev_q == NIL) ? sdtl_pkg::ST_DONE : sdtl_pkg::ST_INS_PREV;
      end
      sdtl_pkg::ST_INS_PREV: state_d = sdtl_pkg::ST_DONE;
      sdtl_pkg::ST_TK_RD: begin
        if (!tk_end) state_d = sdtl_pkg::ST_TK_CHK;
        else if (emit_ready_i) state_d = sdtl_pkg::ST_IDLE;
      end
      sdtl_pkg::ST_TK_CHK: begin
        if (!expired) begin
          if (emit_ready_i) state_d = sdtl_pkg::ST_IDLE;
        end else if (!pend_v_q || emit_ready_i) begin
          state_d = sdtl_pkg::ST_TK_RD;
        end
      end
      sdtl_pkg::ST_DONE: begin
        if (emit_ready_i) state_d = sdtl_pkg::ST_IDLE;
      end
      default: state_d = sdtl_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_d       = req_q;
    time_d      = time_q;
    dl_d        = dl_q;
    head_d      = head_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    nxt_d       = nxt_q;
    armed_d     = armed_q;
    was_d       = was_q;
    cnt_d       = cnt_q;
    pend_v_d    = pend_v_q;
    pend_slot_d = pend_slot_q;
    pend_arg_d  = pend_arg_q;
    l_we        = 1'b0;
    l_waddr     = '0;
    l_wdata     = '0;
    l_re        = 1'b0;
    l_raddr     = '0;
    d_we        = 1'b0;
    d_waddr     = '0;
    d_wdata     = '0;
    d_re        = 1'b0;
    d_raddr     = '0;
    emit_o      = '0;
    case (state_q)
      sdtl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_req_i;
          dl_d     = time_q + in_req_i.delay_ticks;
          was_d    = armed_in;
          cnt_d    = '0;
          pend_v_d = 1'b0;
          if (in_req_i.cmd == sdtl_pkg::CMD_TICK) time_d = time_q + 32'd1;
        end
      end
      sdtl_pkg::ST_UL_HEAD: begin
        l_re    = 1'b1;
        l_raddr = s_idx;
      end
      sdtl_pkg::ST_UL_NXT: begin
        nxt_d = l_rdata;
        if (head_q == s_link) begin
          head_d         = l_rdata;
          armed_d[s_idx] = 1'b0;
        end else begin
          cur_d   = head_q;
          l_re    = 1'b1;
          l_raddr = SW'(head_q);
        end
      end
      sdtl_pkg::ST_UL_WALK: begin
        if (l_rdata == s_link) begin
          l_we           = 1'b1;
          l_waddr        = SW'(cur_q);
          l_wdata        = nxt_q;
          armed_d[s_idx] = 1'b0;
        end else begin
          cur_d   = l_rdata;
          l_re    = 1'b1;
          l_raddr = SW'(l_rdata);
        end
      end
      sdtl_pkg::ST_INS_RD: begin
        d_we    = 1'b1;
        d_waddr = s_idx;
        d_wdata = {dl_q, req_q.user_arg};
        cur_d   = head_q;
        prev_d  = NIL;
        if (head_q != NIL) begin
          l_re    = 1'b1;
          l_raddr = SW'(head_q);
          d_re    = 1'b1;
          d_raddr = SW'(head_q);
        end
      end
      sdtl_pkg::ST_INS_WALK: begin
        if (!ins_stop) begin
          prev_d = cur_q;
          cur_d  = l_rdata;
          if (l_rdata != NIL) begin
            l_re    = 1'b1;
            l_raddr = SW'(l_rdata);
            d_re    = 1'b1;
            d_raddr = SW'(l_rdata);
          end
        end
      end
      sdtl_pkg::ST_INS_LINK: begin
        l_we           = 1'b1;
        l_waddr        = s_idx;
        l_wdata        = cur_q;
        armed_d[s_idx] = 1'b1;
        if (prev_q == NIL) head_d = s_link;
      end
      sdtl_pkg::ST_INS_PREV: begin
        l_we    = 1'b1;
        l_waddr = SW'(prev_q);
        l_wdata = s_link;
      end
      sdtl_pkg::ST_TK_RD: begin
        if (tk_end) begin
          if (emit_ready_i) emit_o = '{valid: 1'b1, res: final_res};
        end else begin
          l_re    = 1'b1;
          l_raddr = SW'(head_q);
          d_re    = 1'b1;
          d_raddr = SW'(head_q);
        end
      end
      sdtl_pkg::ST_TK_CHK: begin
        if (!expired) begin
          if (emit_ready_i) emit_o = '{valid: 1'b1, res: final_res};
        end else if (!pend_v_q || emit_ready_i) begin
          if (pend_v_q) begin
            emit_o = '{valid: 1'b1,
                       res: '{kind: sdtl_pkg::KIND_EXPIRED, slot_out: pend_slot_q,
                              arg_out: pend_arg_q, status: 1'b0, last: 1'b0}};
          end
          pend_v_d              = 1'b1;
          pend_slot_d           = 4'(head_q);
          pend_arg_d            = d_rdata[31:0];
          head_d                = l_rdata;
          armed_d[SW'(head_q)]  = 1'b0;
          cnt_d                 = cnt_q + KW'(1);
        end
      end
      sdtl_pkg::ST_DONE: begin
        if (emit_ready_i) begin
          emit_o.valid            = 1'b1;
          emit_o.res.kind         = (req_q.cmd == sdtl_pkg::CMD_START)
                                    ? sdtl_pkg::KIND_STARTED : sdtl_pkg::KIND_CANCELLED;
          emit_o.res.slot_out     = req_q.slot;
          emit_o.res.arg_out      = 32'd0;
          emit_o.res.status       = (req_q.cmd == sdtl_pkg::CMD_CANCEL) && !was_q;
          emit_o.res.last         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sdtl_pkg::ST_IDLE;
      time_q   <= '0;
      head_q   <= NIL;
      armed_q  <= '0;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      time_q   <= time_d;
      head_q   <= head_d;
      armed_q  <= armed_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    dl_q        <= dl_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    nxt_q       <= nxt_d;
    was_q       <= was_d;
    pend_slot_q <= pend_slot_d;
    pend_arg_q  <= pend_arg_d;
  end

endmodule

### design/sorted_deadline_timer_list_top.sv
// sorted_deadline_timer_list_top: timer list with request and result channels
// depends on sdtl_pkg and sdtl_seq
//
//  channel | direction | handshake                  | payload
//  request | in        | in_valid_i / in_ready_o    | in_req_i  (sdtl_pkg::req_t)
//  result  | out       | out_valid_o / out_ready_i  | out_res_o (sdtl_pkg::res_t)
//
// one request at a time; in_ready_o is high only while the sequencer is idle
// start: unlinks the slot first on restart, then walks the list to insert it by deadline
// cancel: unlinks the slot if it is armed; tick: pops expired timers from the head, up to MAX_RESULTS
// the list walk reads one link memory entry per cycle
// reset clears time, head and armed flags; the memories need no clearing pass
// a held result stalls the sequencer only when it has a new result to hand over
module sorted_deadline_timer_list_top #(
  parameter int unsigned SLOTS = sdtl_pkg::SLOTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sdtl_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sdtl_pkg::res_t out_res_o
);

  sdtl_pkg::emit_t emit;
  logic            emit_ready;
  logic            out_valid_q;
  sdtl_pkg::res_t  out_res_q;

  assign emit_ready = !out_valid_q || out_ready_i;

  sdtl_seq #(.SLOTS(SLOTS)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .emit_ready_i(emit_ready),
    .emit_o      (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_res_q <= emit.res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

### design/sdtl_checker.sv
// sdtl_checker: port-level assertions for the timer list, bound to the top level
// depends on sdtl_pkg and sorted_deadline_timer_list_top
module sdtl_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input sdtl_pkg::req_t in_req_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input sdtl_pkg::res_t out_res_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
    (in_req_i.cmd == sdtl_pkg::CMD_START || in_req_i.cmd == sdtl_pkg::CMD_CANCEL ||
     in_req_i.cmd == sdtl_pkg::CMD_TICK) |=> !in_ready_o)
    else $error("request taken while previous one still in work");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.kind == sdtl_pkg::KIND_TICK_IDLE |->
    out_res_o.last && out_res_o.slot_out == 4'd0 && out_res_o.arg_out == 32'd0)
    else $error("bad idle tick result");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_res_o.kind == sdtl_pkg::KIND_STARTED ||
                    out_res_o.kind == sdtl_pkg::KIND_CANCELLED) |->
    out_res_o.last && out_res_o.arg_out == 32'd0)
    else $error("start or cancel result malformed");

endmodule

bind sorted_deadline_timer_list_top sdtl_checker u_sdtl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_req_i   (in_req_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_res_o  (out_res_o)
);

### test/tb_top.sv
// tb_top: self-checking testbench of sorted_deadline_timer_list_top
// a scoreboard class predicts timer list results; depends on sdtl_pkg and the design
`timescale 1ns / 100ps

class timer_list_scoreboard;
  logic [31:0] now_ticks;
  logic [31:0] due_at [16];
  logic [31:0] arg_mem [16];
  bit          is_armed [16];
  int          nxt [16];
  int          head;
  sdtl_pkg::res_t pending_q [$];
  int errors;
  int expiries;

  function new();
    now_ticks = 0;
    head = 16;
    errors = 0;
    expiries = 0;
    for (int i = 0; i < 16; i++) begin
      due_at[i] = 0;
      arg_mem[i] = 0;
      is_armed[i] = 0;
      nxt[i] = 16;
    end
  endfunction

  function bit detach(int s);
    int prev;
    int cur;
    if (!is_armed[s]) return 0;
    prev = 16;
    cur = head;
    for (int n = 0; n < 16 && cur < 16; n++) begin
      if (cur == s) begin
        if (prev == 16) head = nxt[s];
        else nxt[prev] = nxt[s];
        break;
      end
      prev = cur;
      cur = nxt[cur];
    end
    nxt[s] = 16;
    is_armed[s] = 0;
    return 1;
  endfunction

  function void link_sorted(int s);
    int prev;
    int cur;
    prev = 16;
    cur = head;
    for (int n = 0; n < 16 && cur < 16; n++) begin
      if (due_at[s] < due_at[cur]) break;
      prev = cur;
      cur = nxt[cur];
    end
    nxt[s] = cur;
    if (prev == 16) head = s;
    else nxt[prev] = s;
    is_armed[s] = 1;
  endfunction

  function void push(logic [1:0] kind, logic [3:0] s, logic [31:0] a, logic st, logic l);
    sdtl_pkg::res_t r;
    r.kind = kind;
    r.slot_out = s;
    r.arg_out = a;
    r.status = st;
    r.last = l;
    pending_q.push_back(r);
  endfunction

  function void note_request(sdtl_pkg::req_t q);
    int k;
    int h;
    bit was;
    case (q.cmd)
      sdtl_pkg::CMD_START: begin
        void'(detach(q.slot));
        due_at[q.slot] = now_ticks + q.delay_ticks;
        arg_mem[q.slot] = q.user_arg;
        link_sorted(q.slot);
        push(sdtl_pkg::KIND_STARTED, q.slot, 0, 0, 1);
      end
      sdtl_pkg::CMD_CANCEL: begin
        was = detach(q.slot);
        push(sdtl_pkg::KIND_CANCELLED, q.slot, 0, !was, 1);
      end
      sdtl_pkg::CMD_TICK: begin
        now_ticks = now_ticks + 1;
        k = 0;
        while (k < sdtl_pkg::MAX_RESULTS && head < 16) begin
          h = head;
          if (now_ticks - due_at[h] >= sdtl_pkg::EXPIRY_WINDOW) break;
          head = nxt[h];
          nxt[h] = 16;
          is_armed[h] = 0;
          due_at[h] = 0;
          push(sdtl_pkg::KIND_EXPIRED, h, arg_mem[h], 0, 0);
          k++;
          expiries++;
        end
        if (k == 0) push(sdtl_pkg::KIND_TICK_IDLE, 0, 0, 0, 1);
        else pending_q[$].last = 1;
      end
      default: ;
    endcase
  endfunction

  function void check_result(sdtl_pkg::res_t r);
    sdtl_pkg::res_t e;
    if (pending_q.size() == 0) begin
      $error("unexpected result %p", r);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (r.kind !== e.kind) begin
      $error("kind expected %0d actual %0d", e.kind, r.kind); errors++;
    end
    if (r.slot_out !== e.slot_out) begin
      $error("slot_out expected %0d actual %0d", e.slot_out, r.slot_out); errors++;
    end
    if (r.arg_out !== e.arg_out) begin
      $error("arg_out expected %h actual %h", e.arg_out, r.arg_out); errors++;
    end
    if (r.status !== e.status) begin
      $error("status expected %0d actual %0d", e.status, r.status); errors++;
    end
    if (r.last !== e.last) begin
      $error("last expected %0d actual %0d", e.last, r.last); errors++;
    end
  endfunction
endclass

module tb_top;
  import sdtl_pkg::*;

  localparam logic [1:0] CMD_RSVD = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  res_t out_res_o;

  timer_list_scoreboard sb;
  int cycle_cnt;
  bit calm;
  int n_requests;

  sorted_deadline_timer_list_top uut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("tb_top failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_res_o);
    if (rst_ni) out_ready_i <= calm || ($urandom_range(99) >= 21);
  end

  task automatic send(logic [1:0] c, logic [3:0] s, logic [31:0] d, logic [31:0] a);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_req_i <= '{cmd: c, slot: s, delay_ticks: d, user_arg: a};
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request('{cmd: c, slot: s, delay_ticks: d, user_arg: a});
    n_requests++;
  endtask

  task automatic send_random();
    int p;
    logic [31:0] d;
    p = $urandom_range(99);
    case ($urandom_range(3))
      0: d = $urandom();
      1: d = 32'hFFFF_FFFF - $urandom_range(3);
      default: d = $urandom_range(12);
    endcase
    if (p < 45) send(CMD_START, 4'($urandom_range(15)), d, $urandom());
    else if (p < 60) send(CMD_CANCEL, 4'($urandom_range(15)), $urandom(), $urandom());
    else if (p < 97) send(CMD_TICK, 4'($urandom()), $urandom(), $urandom());
    else send(CMD_RSVD, 4'($urandom()), $urandom(), $urandom());
  endtask

  initial begin
    sb = new();
    cycle_cnt = 0;
    calm = 0;
    n_requests = 0;
    rst_ni = 0;
    in_valid_i = 0;
    in_req_i = '0;
    out_ready_i = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send(CMD_CANCEL, 4'd3, 0, 0);
    send(CMD_START, 4'd0, 32'd0, 32'hFFFF_FFFF);
    send(CMD_START, 4'd15, 32'hFFFF_FFFF, 32'h0);
    send(CMD_START, 4'd1, 32'd2, 32'hA5A5_5A5A);
    send(CMD_START, 4'd2, 32'd2, 32'h5A5A_A5A5);
    send(CMD_START, 4'd1, 32'd3, 32'h1234_5678);
    send(CMD_CANCEL, 4'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(CMD_CANCEL, 4'd2, 0, 0);
    send(CMD_TICK, 0, 0, 0);
    send(CMD_RSVD, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(CMD_TICK, 0, 0, 0);
    send(CMD_TICK, 0, 0, 0);
    send(CMD_START, 4'd5, 32'h1000_0000, 32'd7);
    for (int i = 0; i < 16; i++) send(CMD_START, 4'(i), 32'd1, i * 32'h1111_1111);
    send(CMD_TICK, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(CMD_TICK, 0, 0, 0);
    for (int i = 0; i < 480; i++) begin
      calm = (i >= 200 && i < 260);
      send_random();
    end
    in_valid_i <= 0;
    calm = 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("covered %0d requests with %0d timer expiries, restarts, cancels and wraps",
             n_requests, sb.expiries);
    if (sb.errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule
